/* src/stable_priority_queue_defines.svh */
// shared assertion macros for the priority queue
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SPQ_ASSERT_NOW(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("spq check failed");

// next-cycle implication, disabled while in reset
`define SPQ_ASSERT_NXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("spq check failed");

`endif

/* src/spq_pkg.sv */
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_PEEK   = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic signed [15:0] prio;
    logic [15:0]        id;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_t;

  typedef struct packed {
    logic queue_empty;
    logic queue_full;
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

endpackage

/* src/spq_in_if.sv */
interface spq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [15:0]        task_id;
  logic signed [15:0] task_priority;

  modport source (output valid, output cmd, output task_id, output task_priority,
                  input ready);
  modport sink (input valid, input cmd, input task_id, input task_priority,
                output ready);
endinterface

/* src/spq_out_if.sv */
interface spq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] head_id;
  logic        queue_empty;
  logic [4:0]  entry_count;

  modport source (output valid, output status, output head_id, output queue_empty,
                  output entry_count, input ready);
  modport sink (input valid, input status, input head_id, input queue_empty,
                input entry_count, output ready);
endinterface

/* src/spq_ctrl.sv */
`include "stable_priority_queue_defines.svh"

module spq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output spq_pkg::ctrl_t ctl,
  input  spq_pkg::stat_t sts
);

  spq_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spq_pkg::S_IDLE: begin
        if (in_valid) state_nxt = spq_pkg::S_EXEC;
      end
      spq_pkg::S_EXEC: begin
        state_nxt = spq_pkg::S_DONE;
      end
      spq_pkg::S_DONE: begin
        if (out_ready) state_nxt = spq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready    = (state_r == spq_pkg::S_IDLE);
  assign out_valid   = (state_r == spq_pkg::S_DONE);
  assign ctl.capture = in_valid && in_ready;
  assign ctl.exec    = (state_r == spq_pkg::S_EXEC);

  // sequencing checks
  `SPQ_ASSERT_NXT(a_capture_then_exec, clk, rst_n, ctl.capture, ctl.exec)
  `SPQ_ASSERT_NXT(a_exec_then_result, clk, rst_n, ctl.exec, out_valid && !in_ready)
  `SPQ_ASSERT_NXT(a_taken_then_ready, clk, rst_n, out_valid && out_ready, in_ready)
  `SPQ_ASSERT_NOW(a_full_not_empty, clk, rst_n, sts.queue_full, !sts.queue_empty)

endmodule

/* src/spq_datapath.sv */
`include "stable_priority_queue_defines.svh"

module spq_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::ctrl_t     ctl,
  input  logic [1:0]         cmd,
  input  logic [15:0]        task_id,
  input  logic signed [15:0] task_priority,
  output logic [1:0]         status,
  output logic [15:0]        head_id,
  output logic               queue_empty,
  output logic [4:0]         entry_count,
  output spq_pkg::stat_t     sts
);

  localparam int CAP = spq_pkg::CAPACITY;
  localparam int CW  = spq_pkg::CNT_W;

  // latched operation
  logic [1:0]         op_cmd_r;
  logic [15:0]        op_id_r;
  logic signed [15:0] op_prio_r;

  // sorted entry cells, highest priority at index 0
  spq_pkg::entry_t ent_r   [CAP];
  spq_pkg::entry_t ent_nxt [CAP];
  logic [CW-1:0]   count_r, count_nxt;

  // result register
  logic [1:0]  res_status_r, res_status_nxt;
  logic [15:0] res_head_r, res_head_nxt;
  logic [CW-1:0] res_count_r;

  logic [CAP-1:0] less;
  logic [CAP-1:0] less_prev;
  logic           is_full;
  logic           is_empty;
  logic           ins_ok;
  logic           pop_ok;
  spq_pkg::entry_t new_ent;

  assign is_full  = (count_r == CW'(CAP));
  assign is_empty = (count_r == '0);
  assign new_ent  = '{prio: op_prio_r, id: op_id_r};

  // executing an insert that fits, or a pop on a non-empty list
  assign ins_ok = ctl.exec && (op_cmd_r == spq_pkg::CMD_INSERT) && !is_full;
  assign pop_ok = ctl.exec && (op_cmd_r == spq_pkg::CMD_POP) && !is_empty;

  // per-cell compare: stored entry is valid and of strictly lower priority
  always_comb begin
    for (int k = 0; k < CAP; k++) begin
      less[k] = (CW'(k) < count_r) && (ent_r[k].prio < op_prio_r);
    end
  end

  assign less_prev = {less[CAP-2:0], 1'b0};

  always_comb begin
    for (int k = 0; k < CAP; k++) begin
      ent_nxt[k] = ent_r[k];
    end
    count_nxt      = count_r;
    res_status_nxt = spq_pkg::STAT_OK;
    res_head_nxt   = '0;
    case (op_cmd_r)
      spq_pkg::CMD_INSERT: begin
        if (is_full) begin
          res_status_nxt = spq_pkg::STAT_FULL;
        end else begin
          for (int k = 0; k < CAP; k++) begin
            if (less_prev[k]) begin
              ent_nxt[k] = ent_r[(k + CAP - 1) % CAP];
            end else if (less[k] || (CW'(k) == count_r)) begin
              ent_nxt[k] = new_ent;
            end
          end
          count_nxt = count_r + 1'b1;
        end
      end
      spq_pkg::CMD_POP: begin
        if (is_empty) begin
          res_status_nxt = spq_pkg::STAT_EMPTY;
        end else begin
          res_head_nxt = ent_r[0].id;
          for (int k = 0; k < CAP - 1; k++) begin
            ent_nxt[k] = ent_r[k + 1];
          end
          count_nxt = count_r - 1'b1;
        end
      end
      spq_pkg::CMD_PEEK: begin
        if (is_empty) begin
          res_status_nxt = spq_pkg::STAT_EMPTY;
        end else begin
          res_head_nxt = ent_r[0].id;
        end
      end
      default: begin
        res_status_nxt = spq_pkg::STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op_cmd_r  <= cmd;
      op_id_r   <= task_id;
      op_prio_r <= task_priority;
    end
    if (ctl.exec) begin
      for (int k = 0; k < CAP; k++) begin
        ent_r[k] <= ent_nxt[k];
      end
      res_status_r <= res_status_nxt;
      res_head_r   <= res_head_nxt;
      res_count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.exec) begin
      count_r <= count_nxt;
    end
  end

  assign status          = res_status_r;
  assign head_id         = res_head_r;
  assign queue_empty     = (res_count_r == '0);
  assign entry_count     = 5'(res_count_r);
  assign sts.queue_empty = is_empty;
  assign sts.queue_full  = is_full;

  // count bookkeeping
  `SPQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAP))
  `SPQ_ASSERT_NXT(a_insert_grows, clk, rst_n, ins_ok, count_r == CW'($past(count_r) + 1'b1))
  `SPQ_ASSERT_NXT(a_pop_shrinks, clk, rst_n, pop_ok, count_r == CW'($past(count_r) - 1'b1))

endmodule

/* src/stable_priority_queue.sv */
// an accepted input beat is captured, then executed, before out valid rises
// operations do not overlap: the single controller sequence (capture, execute,
//   hand-off) takes a new input only after out ready has taken the result
// reset: synchronous active-low rst_n clears the entry count and controller state;
//   task entries are not cleared, only entries below the count are ever read
module stable_priority_queue (
  input  logic       clk,
  input  logic       rst_n,
  spq_in_if.sink     in_ch,
  spq_out_if.source  out_ch
);

  // command and status bundles between controller and datapath
  spq_pkg::ctrl_t ctl;
  spq_pkg::stat_t sts;

  // controller: idle -> execute -> hold result until taken
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  // datapath: sorted cell array, each cell compares against the new priority
  // in parallel; insert shifts the lower tail down one cell, pop shifts up
  spq_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .cmd           (in_ch.cmd),
    .task_id       (in_ch.task_id),
    .task_priority (in_ch.task_priority),
    .status        (out_ch.status),
    .head_id       (out_ch.head_id),
    .queue_empty   (out_ch.queue_empty),
    .entry_count   (out_ch.entry_count),
    .sts           (sts)
  );

endmodule
